/* design/ertf_pkg.sv */
package ertf_pkg;

    localparam int SPEED_W = 9;
    localparam int ACCEL_W = 16;
    localparam int GEAR_W  = 3;
    localparam int REC_W   = 3;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 3;
    localparam int STATE_W = 3;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 8;
    localparam int PROD_W  = 41;

    localparam logic [PROD_W-1:0] TICK_SCALE = PROD_W'(417);
    localparam logic [PROD_W-1:0] SEC_SCALE  = PROD_W'(100000);
    localparam logic [3:0]        ACC_SCALE  = 4'd10;

    localparam logic [GEAR_W-1:0] GEAR_PARK    = 3'd0;
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd2;
    localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 3'd3;

    localparam logic [REC_W-1:0] REC_READY     = 3'd0;
    localparam logic [REC_W-1:0] REC_RECORDING = 3'd1;
    localparam logic [REC_W-1:0] REC_COUNTDOWN = 3'd2;
    localparam logic [REC_W-1:0] REC_SLEEPING  = 3'd3;

    localparam logic [IDX_W-1:0] CFG_START_SPEED  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PAUSE_SPEED  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PAUSE_HOLD   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RESUME_SPEED = 3'd3;
    localparam logic [IDX_W-1:0] CFG_RESUME_HOLD  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_ACCEL_LIMIT  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_DECIMATION   = 3'd6;
    localparam logic [IDX_W-1:0] CFG_GEAR_MODE    = 3'd7;

    localparam logic [STATE_W-1:0] CODE_INIT       = 3'd0;
    localparam logic [STATE_W-1:0] CODE_READY      = 3'd1;
    localparam logic [STATE_W-1:0] CODE_RECORD     = 3'd2;
    localparam logic [STATE_W-1:0] CODE_REC_TO_RDY = 3'd3;
    localparam logic [STATE_W-1:0] CODE_EVENT      = 3'd4;
    localparam logic [STATE_W-1:0] CODE_EVT_TO_RDY = 3'd5;

    typedef enum logic [5:0] {
        ST_INIT       = 6'b000001,
        ST_READY      = 6'b000010,
        ST_RECORD     = 6'b000100,
        ST_REC_TO_RDY = 6'b001000,
        ST_EVENT      = 6'b010000,
        ST_EVT_TO_RDY = 6'b100000
    } t_state;

    function automatic logic [STATE_W-1:0] state_code(input t_state st);
        logic [STATE_W-1:0] code;
        unique case (st)
            ST_INIT:       code = CODE_INIT;
            ST_READY:      code = CODE_READY;
            ST_RECORD:     code = CODE_RECORD;
            ST_REC_TO_RDY: code = CODE_REC_TO_RDY;
            ST_EVENT:      code = CODE_EVENT;
            ST_EVT_TO_RDY: code = CODE_EVT_TO_RDY;
            default:       code = CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

/* design/event_recorder_trigger_fsm.sv */
// Trigger machine for a frame recorder. One request is one radar frame on the
// s_axis channel; one result per frame leaves on the m_axis channel.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data,
// one register per cycle; the user must do so only while no frame is in flight,
// which the block itself does not enforce. A frame accepted on s_axis passes
// through the input register, then the decision logic into the result register,
// before it is presented on m_axis. Throughput: one frame per cycle while the
// receiver does not stall. The state, stamp, phase and last acceleration are
// updated in the same cycle the result register is loaded, so consecutive
// frames see each other's effects without a bubble. The longest path is the
// 32x9 elapsed-time multiply and its compare.
// When the receiver stalls, the result register holds; the input register
// still takes one more frame, and s_axis_tready drops once both are full.
// Reset (synchronous, active low) empties both stages, puts the machine in
// init, clears the stamp, phase and last acceleration, and loads register
// defaults.
module event_recorder_trigger_fsm
    import ertf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // speed[8:0], accel_x[24:9], gear[27:25], recorder_state[30:28],
    // timestamp[62:31], zero[63]
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // trigger_state[2:0], start_countdown[3], reset_countdown[4],
    // record_frame[5], zero[7:6]
    output logic [OUT_W-1:0]    m_axis_tdata
);

    logic [CFG_W-1:0] r_start_speed, r_pause_speed, r_pause_hold, r_resume_speed;
    logic [CFG_W-1:0] r_resume_hold, r_accel_limit, r_decimation;
    logic             r_gear_mode;

    logic                      r_in_vld;
    logic [SPEED_W-1:0]        r_in_speed;
    logic signed [ACCEL_W-1:0] r_in_accel;
    logic [GEAR_W-1:0]         r_in_gear;
    logic [REC_W-1:0]          r_in_rec;
    logic [TIME_W-1:0]         r_in_now;

    t_state                    r_state, n_state;
    logic signed [ACCEL_W-1:0] r_prev_accel;
    logic [TIME_W-1:0]         r_stamp, n_stamp;
    logic [CFG_W-1:0]          r_phase, n_phase;

    logic                r_out_vld;
    logic [STATE_W-1:0]  r_out_state;
    logic                r_out_start, r_out_reset, r_out_record;
    logic                n_start, n_reset, n_record;

    logic advance;
    logic take;

    logic [CFG_W-1:0]          dec;
    logic [CFG_W:0]            ph_inc;
    logic signed [ACCEL_W:0]   delta;
    logic signed [ACCEL_W:0]   lim;
    logic                      jump;
    logic                      sleeping;
    logic [TIME_W-1:0]         ticks;
    logic [PROD_W-1:0]         elapsed;
    logic                      pause_met;
    logic                      resume_met;
    logic                      may_record;
    logic                      moved;

    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_speed  <= 8'd255;
            r_pause_speed  <= 8'd0;
            r_pause_hold   <= 8'd1;
            r_resume_speed <= 8'd255;
            r_resume_hold  <= 8'd10;
            r_accel_limit  <= 8'd15;
            r_decimation   <= 8'd255;
            r_gear_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_SPEED:  r_start_speed  <= i_cfg_data;
                CFG_PAUSE_SPEED:  r_pause_speed  <= i_cfg_data;
                CFG_PAUSE_HOLD:   r_pause_hold   <= i_cfg_data;
                CFG_RESUME_SPEED: r_resume_speed <= i_cfg_data;
                CFG_RESUME_HOLD:  r_resume_hold  <= i_cfg_data;
                CFG_ACCEL_LIMIT:  r_accel_limit  <= i_cfg_data;
                CFG_DECIMATION:   r_decimation   <= i_cfg_data;
                CFG_GEAR_MODE:    r_gear_mode    <= i_cfg_data[0];
                default:          r_gear_mode    <= r_gear_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_speed <= s_axis_tdata[8:0];
            r_in_accel <= s_axis_tdata[24:9];
            r_in_gear  <= s_axis_tdata[27:25];
            r_in_rec   <= s_axis_tdata[30:28];
            r_in_now   <= s_axis_tdata[62:31];
        end
    end

    assign dec      = (r_decimation == '0) ? CFG_W'(1) : r_decimation;
    assign ph_inc   = {1'b0, r_phase} + (CFG_W+1)'(1);
    assign delta    = {r_in_accel[ACCEL_W-1], r_in_accel}
                    - {r_prev_accel[ACCEL_W-1], r_prev_accel};
    assign lim      = $signed((ACCEL_W+1)'(r_accel_limit * ACC_SCALE));
    assign jump     = (delta > lim) || (delta < -lim);
    assign sleeping = (r_in_rec == REC_SLEEPING);
    assign ticks    = r_in_now - r_stamp;
    assign elapsed  = PROD_W'(ticks) * TICK_SCALE;

    always_comb begin
        n_state    = r_state;
        n_stamp    = r_stamp;
        n_phase    = (ph_inc >= {1'b0, dec}) ? '0 : ph_inc[CFG_W-1:0];
        n_start    = 1'b0;
        n_reset    = 1'b0;
        may_record = 1'b0;
        moved      = 1'b0;
        pause_met  = 1'b0;
        resume_met = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                n_stamp = r_in_now;
                n_phase = '0;
                if (r_in_rec == REC_READY || r_in_rec == REC_RECORDING) begin
                    n_state = ST_READY;
                end else if (r_in_rec == REC_COUNTDOWN || r_in_rec == REC_SLEEPING) begin
                    n_state = ST_EVENT;
                end
            end
            ST_READY: begin
                if (r_in_speed > SPEED_W'(r_start_speed) ||
                    (r_in_gear == GEAR_DRIVE && r_gear_mode)) begin
                    n_state = ST_RECORD;
                    n_stamp = r_in_now;
                end
            end
            ST_RECORD: begin
                if (jump) begin
                    n_state = ST_EVENT;
                    n_stamp = r_in_now;
                    n_start = 1'b1;
                end
                if ((!r_gear_mode && r_in_speed == SPEED_W'(r_pause_speed) &&
                     r_pause_hold != '0) ||
                    (r_gear_mode && (r_in_gear == GEAR_PARK ||
                                     r_in_gear == GEAR_NEUTRAL))) begin
                    n_state = ST_REC_TO_RDY;
                    n_stamp = r_in_now;
                end
                may_record = 1'b1;
            end
            ST_REC_TO_RDY: begin
                if (jump) begin
                    n_state = ST_EVENT;
                    n_stamp = r_in_now;
                    n_start = 1'b1;
                    moved   = 1'b1;
                end
                if (r_in_speed > SPEED_W'(r_start_speed)) begin
                    n_state = ST_RECORD;
                    n_stamp = r_in_now;
                    moved   = 1'b1;
                end
                pause_met = moved ? (r_pause_hold == '0)
                                  : (elapsed >= PROD_W'(r_pause_hold) * SEC_SCALE);
                if (pause_met || (r_in_gear == GEAR_PARK && r_gear_mode)) begin
                    n_state = ST_READY;
                    n_stamp = r_in_now;
                end
                may_record = 1'b1;
            end
            ST_EVENT: begin
                if (r_in_speed > SPEED_W'(r_resume_speed) && sleeping) begin
                    n_state = ST_EVT_TO_RDY;
                    n_stamp = r_in_now;
                end
                may_record = 1'b1;
            end
            ST_EVT_TO_RDY: begin
                if (r_in_speed < SPEED_W'(r_resume_speed)) begin
                    n_state = ST_EVENT;
                    n_stamp = r_in_now;
                    moved   = 1'b1;
                end
                resume_met = moved ? (r_resume_hold == '0)
                                   : (elapsed >= PROD_W'(r_resume_hold) * SEC_SCALE);
                if (resume_met && sleeping) begin
                    n_state = ST_READY;
                    n_stamp = r_in_now;
                    n_reset = 1'b1;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        n_record = may_record && !sleeping && (n_phase == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_stamp      <= '0;
            r_phase      <= '0;
            r_prev_accel <= '0;
            r_out_vld    <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_state      <= n_state;
                r_stamp      <= n_stamp;
                r_phase      <= n_phase;
                r_prev_accel <= r_in_accel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out_state  <= state_code(n_state);
            r_out_start  <= n_start;
            r_out_reset  <= n_reset;
            r_out_record <= n_record;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_record, r_out_reset, r_out_start, r_out_state};

endmodule
